/* sv/ulcd_pkg.sv */
// Package with the shared types and constants of the UART line command decoder.
`timescale 1ns / 1ps

package ulcd_pkg;

   localparam int LINE_BYTES_DEFAULT   = 15;
   localparam int VALUE_OFFSET_DEFAULT = 4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_TWO   = 8'h32;
   localparam logic [7:0] CH_LC_C  = 8'h63;
   localparam logic [7:0] CH_LC_O  = 8'h6F;
   localparam logic [7:0] CH_LC_P  = 8'h70;
   localparam logic [7:0] CH_LC_R  = 8'h72;
   localparam logic [7:0] CH_LC_S  = 8'h73;

   localparam logic [1:0] OP_STOP   = 2'd0;
   localparam logic [1:0] OP_ON     = 2'd1;
   localparam logic [1:0] OP_PERIOD = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   typedef struct packed {
      logic [7:0] data;
      logic       is_term;
   } queue_word_type;

   typedef struct packed {
      logic [7:0]         echo_byte;
      logic               command_valid;
      logic               to_temp;
      logic               to_light;
      logic [1:0]         opcode;
      logic signed [31:0] period_value;
   } result_type;

endpackage

/* sv/ulcd_front.sv */
// Front part: accepts received bytes, marks line terminators and queues them for the back part.
`timescale 1ns / 1ps

module ulcd_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic [7:0]              req_rx_byte,
   output logic                    q_valid,
   output ulcd_pkg::queue_word_type q_word,
   input  logic                    q_take
);
   import ulcd_pkg::*;

   queue_word_type          q_ff [QUEUE_DEPTH];
   logic [QUEUE_PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]     count_ff, count_in;
   logic                    push_ok;
   logic                    take_ok;
   queue_word_type          new_word;

   assign full    = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_word  = q_ff[rd_ptr_ff];
   assign push_ok = push && !full;
   assign take_ok = q_take && q_valid;

   always_comb begin
      new_word.data    = req_rx_byte;
      new_word.is_term = (req_rx_byte == CH_CR) || (req_rx_byte == CH_LF);
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !take_ok) begin
         count_in = count_ff + 1'b1;
      end else if (take_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= new_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* sv/ulcd_back.sv */
// Back part: line store, command match, decimal decode and the result register.
`timescale 1ns / 1ps

module ulcd_back #(
   parameter int LINE_BYTES   = ulcd_pkg::LINE_BYTES_DEFAULT,
   parameter int VALUE_OFFSET = ulcd_pkg::VALUE_OFFSET_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  ulcd_pkg::queue_word_type q_word,
   output logic                     q_take,
   output logic                     out_valid,
   output ulcd_pkg::result_type     out_word,
   input  logic                     pop
);
   import ulcd_pkg::*;

   localparam int            AW         = $clog2(LINE_BYTES);
   localparam logic [AW-1:0] LAST_IDX   = AW'(LINE_BYTES - 1);
   localparam logic [AW-1:0] OFFSET_IDX = AW'(VALUE_OFFSET);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MATCH  = 2'd1;
   localparam logic [1:0] ST_DECODE = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   logic [7:0]            mem [LINE_BYTES];
   logic [LINE_BYTES-1:0] valid_ff, valid_in;
   logic [7:0]            pre_ff [3];
   logic [7:0]            pre_in [3];
   logic [AW-1:0]         fill_ff, fill_in;
   logic [1:0]            state_ff, state_in;
   logic [AW-1:0]         cursor_ff, cursor_in;
   logic                  digit_phase_ff, digit_phase_in;
   logic                  neg_ff, neg_in;
   logic [31:0]           acc_ff, acc_in;
   logic [7:0]            rd_data_ff;
   logic                  rd_valid_ff;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [7:0]            wr_data;
   result_type            res_ff, res_in;
   result_type            out_ff, out_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  slot_free;
   logic [7:0]            cur_byte;
   logic                  is_digit;
   logic                  is_blank;
   logic                  finish;
   logic [31:0]           digit_val;

   assign out_valid = out_valid_ff;
   assign out_word  = out_ff;
   assign slot_free = !out_valid_ff || pop;
   assign cur_byte  = rd_valid_ff ? rd_data_ff : 8'h00;
   assign is_digit  = (cur_byte >= CH_ZERO) && (cur_byte <= CH_NINE);
   assign is_blank  = (cur_byte == CH_SPACE) || ((cur_byte >= CH_TAB) && (cur_byte <= CH_CR));
   assign digit_val = {24'd0, cur_byte - CH_ZERO};

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      valid_in       = valid_ff;
      pre_in         = pre_ff;
      cursor_in      = cursor_ff;
      digit_phase_in = digit_phase_ff;
      neg_in         = neg_ff;
      acc_in         = acc_ff;
      res_in         = res_ff;
      out_in         = out_ff;
      out_valid_in   = out_valid_ff && !pop;
      q_take         = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = fill_ff;
      wr_data        = q_word.data;
      rd_addr        = cursor_ff + 1'b1;
      finish         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && q_word.is_term) begin
               q_take                = 1'b1;
               wr_en                 = 1'b1;
               wr_data               = 8'h00;
               res_in                = '0;
               res_in.echo_byte      = q_word.data;
               state_in              = ST_MATCH;
            end else if (q_valid && slot_free) begin
               q_take                = 1'b1;
               out_in                = '0;
               out_in.echo_byte      = q_word.data;
               out_valid_in          = 1'b1;
               if (fill_ff < LAST_IDX) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + 1'b1;
               end else begin
                  fill_in = '0;
               end
            end
            if (wr_en) begin
               valid_in[wr_addr] = 1'b1;
               if (wr_addr < AW'(3)) begin
                  pre_in[wr_addr[1:0]] = wr_data;
               end
            end
         end
         ST_MATCH: begin
            fill_in        = '0;
            rd_addr        = OFFSET_IDX;
            cursor_in      = OFFSET_IDX;
            digit_phase_in = 1'b0;
            neg_in         = 1'b0;
            acc_in         = '0;
            state_in       = ST_EMIT;
            res_in.command_valid = 1'b1;
            if (pre_ff[0] == CH_LC_S && pre_ff[1] == CH_LC_C) begin
               res_in.to_temp  = 1'b1;
               res_in.to_light = 1'b1;
               res_in.opcode   = OP_STOP;
            end else if (pre_ff[0] == CH_LC_O && pre_ff[1] == CH_LC_R && pre_ff[2] == CH_ONE) begin
               res_in.to_temp = 1'b1;
               res_in.opcode  = OP_ON;
            end else if (pre_ff[0] == CH_LC_O && pre_ff[1] == CH_LC_R && pre_ff[2] == CH_TWO) begin
               res_in.to_light = 1'b1;
               res_in.opcode   = OP_ON;
            end else if (pre_ff[0] == CH_LC_P && pre_ff[1] == CH_LC_R && pre_ff[2] == CH_ONE) begin
               res_in.to_temp = 1'b1;
               res_in.opcode  = OP_PERIOD;
               state_in       = ST_DECODE;
            end else if (pre_ff[0] == CH_LC_P && pre_ff[1] == CH_LC_R && pre_ff[2] == CH_TWO) begin
               res_in.to_light = 1'b1;
               res_in.opcode   = OP_PERIOD;
               state_in        = ST_DECODE;
            end else if (pre_ff[0] == CH_LC_C && pre_ff[1] == CH_LC_R && pre_ff[2] == CH_ONE) begin
               res_in.to_temp = 1'b1;
               res_in.opcode  = OP_CLEAR;
            end else if (pre_ff[0] == CH_LC_C && pre_ff[1] == CH_LC_R && pre_ff[2] == CH_TWO) begin
               res_in.to_light = 1'b1;
               res_in.opcode   = OP_CLEAR;
            end else begin
               res_in.command_valid = 1'b0;
            end
         end
         ST_DECODE: begin
            if (!digit_phase_ff) begin
               if (is_blank) begin
                  finish = 1'b0;
               end else if (cur_byte == CH_PLUS || cur_byte == CH_MINUS) begin
                  neg_in         = (cur_byte == CH_MINUS);
                  digit_phase_in = 1'b1;
               end else if (is_digit) begin
                  acc_in         = digit_val;
                  digit_phase_in = 1'b1;
               end else begin
                  finish = 1'b1;
               end
            end else if (is_digit) begin
               acc_in = (acc_ff << 3) + (acc_ff << 1) + digit_val;
            end else begin
               finish = 1'b1;
            end
            if (cursor_ff == LAST_IDX) begin
               finish = 1'b1;
            end
            cursor_in = cursor_ff + 1'b1;
            if (finish) begin
               res_in.period_value = neg_in ? -$signed(acc_in) : $signed(acc_in);
               state_in            = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      cursor_ff      <= cursor_in;
      digit_phase_ff <= digit_phase_in;
      neg_ff         <= neg_in;
      acc_ff         <= acc_in;
      res_ff         <= res_in;
      out_ff         <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         valid_ff     <= '0;
         pre_ff       <= '{default: 8'h00};
         out_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         valid_ff     <= valid_in;
         pre_ff       <= pre_in;
         out_valid_ff <= out_valid_in;
         rd_valid_ff  <= valid_ff[rd_addr];
      end
   end

endmodule

/* sv/uart_line_command_decoder.sv */
// Top level of the UART line command decoder: front queue and back engine.
//
//   Channel   Ports                                   Word accepted when
//   request   push, full, req_rx_byte                 push && !full
//   response  empty, pop, rsp_echo_byte ...           pop && !empty
//
// A data byte passes through the front queue into the response register. A
// terminator passes from the queue through ST_IDLE, ST_MATCH and ST_EMIT, and
// for a period command through ST_DECODE before ST_EMIT, decoding the line
// bytes from VALUE_OFFSET on, at most LINE_BYTES - VALUE_OFFSET, one read per
// cycle from the line store memory. Reset clears the line store valid bits at
// once, so no clearing pass is needed. A response held by pop low stalls the
// back engine, and the two-word queue then fills and raises full.
`timescale 1ns / 1ps

module uart_line_command_decoder #(
   parameter int LINE_BYTES   = ulcd_pkg::LINE_BYTES_DEFAULT,
   parameter int VALUE_OFFSET = ulcd_pkg::VALUE_OFFSET_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [7:0]         req_rx_byte,
   output logic               empty,
   input  logic               pop,
   output logic [7:0]         rsp_echo_byte,
   output logic               rsp_command_valid,
   output logic               rsp_to_temp,
   output logic               rsp_to_light,
   output logic [1:0]         rsp_opcode,
   output logic signed [31:0] rsp_period_value
);
   import ulcd_pkg::*;

   logic           q_valid;
   queue_word_type q_word;
   logic           q_take;
   logic           out_valid;
   result_type     out_word;

   ulcd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_rx_byte (req_rx_byte),
      .q_valid     (q_valid),
      .q_word      (q_word),
      .q_take      (q_take)
   );

   ulcd_back #(
      .LINE_BYTES   (LINE_BYTES),
      .VALUE_OFFSET (VALUE_OFFSET)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_word    (q_word),
      .q_take    (q_take),
      .out_valid (out_valid),
      .out_word  (out_word),
      .pop       (pop)
   );

   assign empty             = !out_valid;
   assign rsp_echo_byte     = out_word.echo_byte;
   assign rsp_command_valid = out_word.command_valid;
   assign rsp_to_temp       = out_word.to_temp;
   assign rsp_to_light      = out_word.to_light;
   assign rsp_opcode        = out_word.opcode;
   assign rsp_period_value  = out_word.period_value;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the UART line command decoder.
`timescale 1ns / 1ps

module tb_top;
   import ulcd_pkg::*;

   localparam int STORE_BYTES = LINE_BYTES_DEFAULT;
   localparam int VALUE_START = VALUE_OFFSET_DEFAULT;
   localparam int CMD_COUNT   = 7;

   localparam logic [7:0] CH_VT = 8'h0B;
   localparam logic [7:0] CH_FF = 8'h0C;

   // Commands in match order: sc, or1, or2, pr1, pr2, cr1, cr2.
   localparam int CMD_LEN [CMD_COUNT] = '{2, 3, 3, 3, 3, 3, 3};
   localparam logic [7:0] CMD_FIRST [CMD_COUNT] =
      '{CH_LC_S, CH_LC_O, CH_LC_O, CH_LC_P, CH_LC_P, CH_LC_C, CH_LC_C};
   localparam logic [7:0] CMD_SECOND [CMD_COUNT] =
      '{CH_LC_C, CH_LC_R, CH_LC_R, CH_LC_R, CH_LC_R, CH_LC_R, CH_LC_R};
   localparam logic [7:0] CMD_THIRD [CMD_COUNT] =
      '{8'h00, CH_ONE, CH_TWO, CH_ONE, CH_TWO, CH_ONE, CH_TWO};
   localparam logic [1:0] CMD_OP [CMD_COUNT] =
      '{OP_STOP, OP_ON, OP_ON, OP_PERIOD, OP_PERIOD, OP_CLEAR, OP_CLEAR};
   localparam bit CMD_TEMP [CMD_COUNT]  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
   localparam bit CMD_LIGHT [CMD_COUNT] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
   localparam logic [7:0] BLANKS [4] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};

   class line_command_model;
      logic [7:0] line_mem [STORE_BYTES];
      int         fill;
      result_type pending_responses [$];
      int         inputs;
      int         checked;
      int         errors;
      int         op_count [4];

      function new();
         foreach (line_mem[i]) line_mem[i] = 8'h00;
         fill = 0;
         inputs = 0;
         checked = 0;
         errors = 0;
         foreach (op_count[i]) op_count[i] = 0;
      endfunction

      function int pending();
         return pending_responses.size();
      endfunction

      function void note_byte(logic [7:0] b);
         result_type r;
         bit         hit;
         bit         neg;
         int         i;
         logic [31:0] acc;
         r = '0;
         r.echo_byte = b;
         inputs++;
         if (b == CH_CR || b == CH_LF) begin
            if (fill < STORE_BYTES) line_mem[fill] = 8'h00;
            hit = 1'b0;
            for (int k = 0; k < CMD_COUNT && !hit; k++) begin
               if (line_mem[0] == CMD_FIRST[k] && line_mem[1] == CMD_SECOND[k] &&
                   (CMD_LEN[k] == 2 || line_mem[2] == CMD_THIRD[k])) begin
                  hit = 1'b1;
                  r.command_valid = 1'b1;
                  r.to_temp = CMD_TEMP[k];
                  r.to_light = CMD_LIGHT[k];
                  r.opcode = CMD_OP[k];
                  op_count[CMD_OP[k]]++;
                  if (CMD_OP[k] == OP_PERIOD) begin
                     i = VALUE_START;
                     acc = '0;
                     neg = 1'b0;
                     while (i < STORE_BYTES && (line_mem[i] == CH_SPACE ||
                            (line_mem[i] >= CH_TAB && line_mem[i] <= CH_CR)))
                        i++;
                     if (i < STORE_BYTES &&
                         (line_mem[i] == CH_PLUS || line_mem[i] == CH_MINUS)) begin
                        neg = (line_mem[i] == CH_MINUS);
                        i++;
                     end
                     while (i < STORE_BYTES &&
                            line_mem[i] >= CH_ZERO && line_mem[i] <= CH_NINE) begin
                        acc = acc * 32'd10 + 32'(line_mem[i] - CH_ZERO);
                        i++;
                     end
                     r.period_value = neg ? -acc : acc;
                  end
               end
            end
            fill = 0;
         end else if (fill < STORE_BYTES - 1) begin
            line_mem[fill] = b;
            fill++;
         end else begin
            fill = 0;
         end
         pending_responses.push_back(r);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      task check_response(result_type got);
         result_type e;
         if (pending_responses.size() == 0) begin
            report_mismatch($sformatf("response with echo %02h arrived with nothing expected",
                                      got.echo_byte));
            return;
         end
         e = pending_responses.pop_front();
         if (got.echo_byte !== e.echo_byte)
            report_mismatch($sformatf("word %0d echo_byte: got %02h, expected %02h",
                                      checked, got.echo_byte, e.echo_byte));
         if (got.command_valid !== e.command_valid)
            report_mismatch($sformatf("word %0d command_valid: got %0b, expected %0b",
                                      checked, got.command_valid, e.command_valid));
         if (got.to_temp !== e.to_temp)
            report_mismatch($sformatf("word %0d to_temp: got %0b, expected %0b",
                                      checked, got.to_temp, e.to_temp));
         if (got.to_light !== e.to_light)
            report_mismatch($sformatf("word %0d to_light: got %0b, expected %0b",
                                      checked, got.to_light, e.to_light));
         if (got.opcode !== e.opcode)
            report_mismatch($sformatf("word %0d opcode: got %0d, expected %0d",
                                      checked, got.opcode, e.opcode));
         if (got.period_value !== e.period_value)
            report_mismatch($sformatf("word %0d period_value: got %0d, expected %0d",
                                      checked, got.period_value, e.period_value));
         checked++;
      endtask
   endclass

   localparam int CYCLE_LIMIT  = 400000;
   localparam int BYTES_TARGET = 1425;
   localparam int LONG_HOLD    = 300;

   typedef enum {POP_ALWAYS, POP_MOSTLY, POP_SPARSE} pop_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               full;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               empty;
   logic               pop = 1'b0;
   logic [7:0]         rsp_echo_byte;
   logic               rsp_command_valid;
   logic               rsp_to_temp;
   logic               rsp_to_light;
   logic [1:0]         rsp_opcode;
   logic signed [31:0] rsp_period_value;

   line_command_model model = new();
   logic [7:0]        tx_q [$];
   bit                long_hold_req = 1'b0;
   int                burst_left = 0;
   int                full_stalls = 0;
   int                cycle_count = 0;

   uart_line_command_decoder uut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_rx_byte(req_rx_byte),
      .empty(empty),
      .pop(pop),
      .rsp_echo_byte(rsp_echo_byte),
      .rsp_command_valid(rsp_command_valid),
      .rsp_to_temp(rsp_to_temp),
      .rsp_to_light(rsp_to_light),
      .rsp_opcode(rsp_opcode),
      .rsp_period_value(rsp_period_value)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && push && full) full_stalls++;
      if (!reset && pop && !empty)
         model.check_response({rsp_echo_byte, rsp_command_valid, rsp_to_temp,
                               rsp_to_light, rsp_opcode, rsp_period_value});
   end

   // The receiver runs its own stall pattern and takes long holds on request.
   initial begin
      pop_mode_type mode;
      int           mode_left;
      int           hold_left;
      mode = POP_ALWAYS;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req && hold_left == 0) begin
            hold_left = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = pop_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(8, 120);
            end
            mode_left--;
            case (mode)
               POP_ALWAYS: pop <= 1'b1;
               POP_MOSTLY: pop <= ($urandom_range(0, 2) != 0);
               default: pop <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task send_word(logic [7:0] b);
      @(negedge clock);
      push <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (full);
      model.note_byte(b);
   endtask

   task idle_sender(int n);
      repeat (n) begin
         @(negedge clock);
         push <= 1'b0;
      end
   endtask

   task send_paced(logic [7:0] b);
      if (burst_left == 0) begin
         idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      send_word(b);
   endtask

   task wait_drained();
      @(negedge clock);
      push <= 1'b0;
      while (model.pending() != 0) @(posedge clock);
   endtask

   function void queue_command(int k);
      tx_q.push_back(CMD_FIRST[k]);
      tx_q.push_back(CMD_SECOND[k]);
      if (CMD_LEN[k] == 3) tx_q.push_back(CMD_THIRD[k]);
   endfunction

   function logic [7:0] terminator();
      return $urandom_range(0, 1) ? CH_CR : CH_LF;
   endfunction

   initial begin
      int  k;
      int  kind;
      int  pos;
      int  next_drain;
      bit  hold_done;
      next_drain = 350;
      hold_done = 1'b0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed lines: stop, on, period with sign, period reading stale bytes,
      // zero and all-ones data bytes on an unknown line, clear with trailing text.
      queue_command(0);
      tx_q.push_back(CH_CR);
      queue_command(1);
      tx_q.push_back(CH_LF);
      queue_command(4);
      tx_q.push_back(CH_SPACE);
      tx_q.push_back(CH_MINUS);
      tx_q.push_back(8'(CH_ZERO + 7));
      tx_q.push_back(CH_CR);
      queue_command(3);
      tx_q.push_back(CH_LF);
      tx_q.push_back(8'h00);
      tx_q.push_back(8'hFF);
      tx_q.push_back(CH_LF);
      queue_command(6);
      tx_q.push_back(CH_LC_S);
      tx_q.push_back(CH_CR);
      while (tx_q.size() > 0) send_paced(tx_q.pop_front());
      wait_drained();

      while (model.inputs < BYTES_TARGET) begin
         kind = $urandom_range(0, 99);
         k = $urandom_range(0, CMD_COUNT - 1);
         if (kind < 70) begin
            queue_command(k);
            if (CMD_OP[k] == OP_PERIOD) begin
               repeat ($urandom_range(0, 2)) tx_q.push_back(BLANKS[$urandom_range(0, 3)]);
               case ($urandom_range(0, 3))
                  1: tx_q.push_back(CH_PLUS);
                  2: tx_q.push_back(CH_MINUS);
                  default: ;
               endcase
               repeat ($urandom_range(0, 11)) tx_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            end
            if ($urandom_range(0, 4) == 0) tx_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
            tx_q.push_back(terminator());
         end else if (kind < 80) begin
            queue_command(k);
            pos = tx_q.size() - 1 - $urandom_range(0, CMD_LEN[k] - 1);
            tx_q[pos] = 8'($urandom_range(8'h10, 8'hFF));
            tx_q.push_back(terminator());
         end else if (kind < 90) begin
            queue_command(k);
            repeat ($urandom_range(11, 20)) begin
               if ($urandom_range(0, 1)) tx_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
               else tx_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
            end
            tx_q.push_back(terminator());
         end else begin
            repeat ($urandom_range(1, 8)) tx_q.push_back(8'($urandom_range(0, 255)));
         end
         while (tx_q.size() > 0) send_paced(tx_q.pop_front());

         if (!hold_done && model.inputs >= 500) begin
            long_hold_req = 1'b1;
            repeat (32) send_word(8'($urandom_range(0, 255)));
            hold_done = 1'b1;
         end
         if (model.inputs >= next_drain) begin
            wait_drained();
            next_drain += 350;
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);

      $display("Sent %0d bytes and checked %0d responses.", model.inputs, model.checked);
      $display("Commands: stop %0d, on %0d, period %0d, clear %0d.",
               model.op_count[OP_STOP], model.op_count[OP_ON],
               model.op_count[OP_PERIOD], model.op_count[OP_CLEAR]);
      $display("Input held off by full for %0d cycles over %0d cycles; %0d mismatches.",
               full_stalls, cycle_count, model.errors);
      if (model.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

/* files.f */
sv/ulcd_pkg.sv
sv/ulcd_front.sv
sv/ulcd_back.sv
sv/uart_line_command_decoder.sv
tb/tb_top.sv
